### sv/dpa_pkg.sv
// Shared types, constants and the direction microprogram of the particle aggregator.
// No dependencies; used by every other file of the block.
package dpa_pkg;

  localparam int FRAC_BITS   = 8;
  localparam int ANGLE_W     = 10;
  localparam int RADIUS_W    = 17;
  localparam int TARGET_W    = 11;
  localparam int COORD_W     = 20;
  localparam int STORE_W     = 18;
  localparam int EVENT_W     = 2;

  localparam logic [30:0] Q30_ONE  = 31'd1 << 30;
  localparam logic [29:0] PI4_Q30  = 30'd843314857;
  localparam logic [7:0]  HALF_Q   = 8'd128;
  localparam logic [4:0]  DIR_LAST = 5'd27;

  localparam logic [1:0] REG_LAUNCH = 2'd0;
  localparam logic [1:0] REG_STICK  = 2'd1;
  localparam logic [1:0] REG_STEP   = 2'd2;
  localparam logic [1:0] REG_TARGET = 2'd3;

  localparam logic [EVENT_W-1:0] EV_MOVING  = 2'd0;
  localparam logic [EVENT_W-1:0] EV_STORED  = 2'd1;
  localparam logic [EVENT_W-1:0] EV_DROPPED = 2'd2;
  localparam logic [EVENT_W-1:0] EV_TARGET  = 2'd3;

  localparam logic [31:0] RECIP_72 = 32'((64'd1 << 32) / 72);
  localparam logic [31:0] RECIP_42 = 32'((64'd1 << 32) / 42);
  localparam logic [31:0] RECIP_20 = 32'((64'd1 << 32) / 20);
  localparam logic [31:0] RECIP_6  = 32'((64'd1 << 32) / 6);
  localparam logic [31:0] RECIP_90 = 32'((64'd1 << 32) / 90);
  localparam logic [31:0] RECIP_56 = 32'((64'd1 << 32) / 56);
  localparam logic [31:0] RECIP_30 = 32'((64'd1 << 32) / 30);
  localparam logic [31:0] RECIP_12 = 32'((64'd1 << 32) / 12);
  localparam logic [31:0] RECIP_2  = 32'((64'd1 << 32) / 2);

  typedef enum logic [2:0] {
    UOP_NONE, UOP_X, UOP_X2, UOP_QE, UOP_QF, UOP_PM, UOP_SIN
  } uop_t;

  typedef enum logic [3:0] {
    K72, K42, K20, K6, K90, K56, K30, K12, K2
  } kcode_t;

  typedef struct packed {
    uop_t   uop;
    logic   src_p;
    kcode_t k;
  } uinstr_t;

  typedef struct packed {
    logic    load;
    logic    tgt;
    logic    wsq;
    logic    rel;
    uinstr_t ui;
    logic    scale;
    logic    move;
    logic    scan_start;
    logic    scan_en;
    logic    decide;
    logic    publish;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic scan_done;
  } dp_status_t;

  function automatic logic [6:0] k_value(input kcode_t k);
    logic [6:0] v;
    case (k)
      K72: v = 7'd72;
      K42: v = 7'd42;
      K20: v = 7'd20;
      K6:  v = 7'd6;
      K90: v = 7'd90;
      K56: v = 7'd56;
      K30: v = 7'd30;
      K12: v = 7'd12;
      K2:  v = 7'd2;
      default: v = 7'd2;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] k_recip(input kcode_t k);
    logic [31:0] v;
    case (k)
      K72: v = RECIP_72;
      K42: v = RECIP_42;
      K20: v = RECIP_20;
      K6:  v = RECIP_6;
      K90: v = RECIP_90;
      K56: v = RECIP_56;
      K30: v = RECIP_30;
      K12: v = RECIP_12;
      K2:  v = RECIP_2;
      default: v = RECIP_2;
    endcase
    return v;
  endfunction

  // Sine polynomial first, then cosine; the cosine ends in the t register.
  function automatic uinstr_t uprog(input logic [4:0] step);
    uinstr_t u;
    u = '{uop: UOP_NONE, src_p: 1'b1, k: K2};
    case (step)
      5'd0:  u.uop = UOP_X;
      5'd1:  u.uop = UOP_X2;
      5'd2:  u = '{uop: UOP_QE, src_p: 1'b0, k: K72};
      5'd3:  u = '{uop: UOP_QF, src_p: 1'b0, k: K72};
      5'd4:  u.uop = UOP_PM;
      5'd5:  u = '{uop: UOP_QE, src_p: 1'b1, k: K42};
      5'd6:  u = '{uop: UOP_QF, src_p: 1'b1, k: K42};
      5'd7:  u.uop = UOP_PM;
      5'd8:  u = '{uop: UOP_QE, src_p: 1'b1, k: K20};
      5'd9:  u = '{uop: UOP_QF, src_p: 1'b1, k: K20};
      5'd10: u.uop = UOP_PM;
      5'd11: u = '{uop: UOP_QE, src_p: 1'b1, k: K6};
      5'd12: u = '{uop: UOP_QF, src_p: 1'b1, k: K6};
      5'd13: u.uop = UOP_SIN;
      5'd14: u = '{uop: UOP_QE, src_p: 1'b0, k: K90};
      5'd15: u = '{uop: UOP_QF, src_p: 1'b0, k: K90};
      5'd16: u.uop = UOP_PM;
      5'd17: u = '{uop: UOP_QE, src_p: 1'b1, k: K56};
      5'd18: u = '{uop: UOP_QF, src_p: 1'b1, k: K56};
      5'd19: u.uop = UOP_PM;
      5'd20: u = '{uop: UOP_QE, src_p: 1'b1, k: K30};
      5'd21: u = '{uop: UOP_QF, src_p: 1'b1, k: K30};
      5'd22: u.uop = UOP_PM;
      5'd23: u = '{uop: UOP_QE, src_p: 1'b1, k: K12};
      5'd24: u = '{uop: UOP_QF, src_p: 1'b1, k: K12};
      5'd25: u.uop = UOP_PM;
      5'd26: u = '{uop: UOP_QE, src_p: 1'b1, k: K2};
      5'd27: u = '{uop: UOP_QF, src_p: 1'b1, k: K2};
      default: u.uop = UOP_NONE;
    endcase
    return u;
  endfunction

endpackage

### sv/dpa_in_if.sv
// Input channel: one random angle word per handshake.
// Depends on dpa_pkg for the field width.
interface dpa_in_if;
  import dpa_pkg::*;
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] angle;
  modport source (output valid, output angle, input ready);
  modport sink (input valid, input angle, output ready);
endinterface

### sv/dpa_out_if.sv
// Result channel: event code, walker position and stored particle count.
// Depends on dpa_pkg for the field widths.
interface dpa_out_if;
  import dpa_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [EVENT_W-1:0]        event_res;
  logic signed [COORD_W-1:0] walker_x_out;
  logic signed [COORD_W-1:0] walker_y_out;
  logic [TARGET_W-1:0]       stored_count;
  modport source (output valid, output event_res, output walker_x_out,
                  output walker_y_out, output stored_count, input ready);
  modport sink (input valid, input event_res, input walker_x_out,
                input walker_y_out, input stored_count, output ready);
endinterface

### sv/dla_particle_aggregator_core.sv
// From the accepting edge a word goes straight to publish when the target is reached, else
// through setup, the 28-step direction microprogram, scale, move, scan start, one stored
// particle per cycle, draining the read pipeline, decide and publish. One word is in work at
// a time: the next is accepted only after publish, and publish waits while a result word waits.
// Reset is synchronous: the aggregate holds only the origin seed, the walker is idle at the
// origin and the registers take their documented reset values.
module dla_particle_aggregator_core #(
  parameter int MAX_PARTICLES = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  dpa_in_if.sink                            in_word,
  dpa_out_if.source                         out_word,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_addr,
  input  logic [dpa_pkg::RADIUS_W-1:0]      cfg_wdata
);
  import dpa_pkg::*;

  logic [RADIUS_W-1:0] launch_r, stick_r, step_r;
  logic [TARGET_W-1:0] target_r;
  dp_cmd_t    cmd;
  dp_status_t status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      launch_r <= RADIUS_W'(12800);
      stick_r  <= RADIUS_W'(256);
      step_r   <= RADIUS_W'(256);
      target_r <= TARGET_W'(1024);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LAUNCH: launch_r <= cfg_wdata;
        REG_STICK:  stick_r  <= cfg_wdata;
        REG_STEP:   step_r   <= cfg_wdata;
        REG_TARGET: target_r <= cfg_wdata[TARGET_W-1:0];
        default: ;
      endcase
    end
  end

  dpa_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_word.valid),
    .in_ready  (in_word.ready),
    .out_valid (out_word.valid),
    .out_ready (out_word.ready),
    .status    (status),
    .cmd       (cmd)
  );

  dpa_datapath #(.MAX_PARTICLES(MAX_PARTICLES)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .angle         (in_word.angle),
    .launch_radius (launch_r),
    .stick_radius  (stick_r),
    .step_length   (step_r),
    .target_count  (target_r),
    .res_event     (out_word.event_res),
    .res_x         (out_word.walker_x_out),
    .res_y         (out_word.walker_y_out),
    .res_count     (out_word.stored_count)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_word.valid && in_word.ready |=> !in_word.ready)
    else $error("input accepted again while a step is in work");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid |-> 32'(out_word.stored_count) <= MAX_PARTICLES)
    else $error("stored count beyond store depth");

  a_stored_grows: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid && out_word.event_res == EV_STORED |-> out_word.stored_count >= 11'd2)
    else $error("stored event without a new particle");

endmodule

### sv/dpa_datapath.sv
// Datapath: direction polynomial unit, walker update, particle store and contact scan.
// Depends on dpa_pkg; driven by commands from dpa_controller.
module dpa_datapath #(
  parameter int MAX_PARTICLES = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dpa_pkg::dp_cmd_t                   cmd,
  output dpa_pkg::dp_status_t                status,
  input  logic [dpa_pkg::ANGLE_W-1:0]        angle,
  input  logic [dpa_pkg::RADIUS_W-1:0]       launch_radius,
  input  logic [dpa_pkg::RADIUS_W-1:0]       stick_radius,
  input  logic [dpa_pkg::RADIUS_W-1:0]       step_length,
  input  logic [dpa_pkg::TARGET_W-1:0]       target_count,
  output logic [dpa_pkg::EVENT_W-1:0]        res_event,
  output logic signed [dpa_pkg::COORD_W-1:0] res_x,
  output logic signed [dpa_pkg::COORD_W-1:0] res_y,
  output logic [dpa_pkg::TARGET_W-1:0]       res_count
);
  import dpa_pkg::*;

  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam int AW = $clog2(MAX_PARTICLES);

  logic [ANGLE_W-1:0] angle_r;
  logic [35:0] lim2_r;
  logic [33:0] st2_r, rr2_r;
  logic [39:0] sqx_r, sqy_r;
  logic        relaunch_r;
  logic [29:0] x_r, x2_r;
  logic [30:0] p_r, src_r, qest_r, t_r, s_r;
  logic signed [COORD_W-1:0] stepx_r, stepy_r, wx_r, wy_r;
  logic        active_r;
  logic [CW-1:0] count_r, rd_idx_r;
  logic [EVENT_W-1:0] event_r;
  logic v1_r, v2_r, z1_r, hit_r;
  logic [STORE_W-1:0] rdx_r, rdy_r;
  logic [41:0] dsx_r, dsy_r;
  logic [STORE_W-1:0] mem_x [MAX_PARTICLES];
  logic [STORE_W-1:0] mem_y [MAX_PARTICLES];

  logic        swap;
  logic [8:0]  rr;
  logic [38:0] xprod;
  logic [30:0] src;
  logic [6:0]  kval;
  logic [31:0] rem;
  logic [30:0] qfix;
  logic [30:0] sa, ca, cm, sm;
  logic        cn, sn;
  logic [RADIUS_W-1:0] len;
  logic [47:0] prodx, prody;
  logic [17:0] magx, magy;
  logic [17:0] lim;
  logic signed [20:0] dx, dy, rx, ry;
  logic signed [41:0] dxs, dys;
  logic signed [39:0] wxs, wys;
  logic [40:0] w2;
  logic [42:0] d2;
  logic        rd_go, store;

  assign swap  = angle_r[7:0] > HALF_Q;
  assign rr    = swap ? (9'd256 - {1'b0, angle_r[7:0]}) : {1'b0, angle_r[7:0]};
  assign xprod = 39'(rr) * 39'(PI4_Q30);
  assign src   = cmd.ui.src_p ? p_r : {1'b0, x2_r};
  assign kval  = k_value(cmd.ui.k);
  assign rem   = {1'b0, src_r} - 32'(qest_r) * 32'(kval);
  assign qfix  = qest_r + 31'(rem >= 32'(kval));

  assign sa = swap ? t_r : s_r;
  assign ca = swap ? s_r : t_r;
  always_comb begin
    case (angle_r[9:8])
      2'd0: begin cm = ca; cn = 1'b0; sm = sa; sn = 1'b0; end
      2'd1: begin cm = sa; cn = 1'b1; sm = ca; sn = 1'b0; end
      2'd2: begin cm = ca; cn = 1'b1; sm = sa; sn = 1'b1; end
      default: begin cm = sa; cn = 1'b0; sm = ca; sn = 1'b1; end
    endcase
  end

  assign len   = relaunch_r ? launch_radius : step_length;
  assign prodx = 48'(len) * 48'(cm) + (48'd1 << 29);
  assign prody = 48'(len) * 48'(sm) + (48'd1 << 29);
  assign magx  = prodx[47:30];
  assign magy  = prody[47:30];

  assign lim = 18'(launch_radius) + 18'(1 << (FRAC_BITS - 1));
  assign wxs = wx_r * wx_r;
  assign wys = wy_r * wy_r;
  assign w2  = 41'(sqx_r) + 41'(sqy_r);

  assign rd_go = cmd.scan_en && (rd_idx_r < count_r);
  assign rx = z1_r ? 21'sd0 : 21'(signed'(rdx_r));
  assign ry = z1_r ? 21'sd0 : 21'(signed'(rdy_r));
  assign dx = 21'(wx_r) - rx;
  assign dy = 21'(wy_r) - ry;
  assign dxs = dx * dx;
  assign dys = dy * dy;
  assign d2  = 43'(dsx_r) + 43'(dsy_r);
  assign store = hit_r && (w2 < 41'(rr2_r)) && (32'(count_r) < MAX_PARTICLES);

  assign status.full = (32'(count_r) >= 32'(target_count)) ||
                       (32'(count_r) >= MAX_PARTICLES);
  assign status.scan_done = (rd_idx_r == count_r) && !v1_r && !v2_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      angle_r <= angle;
      lim2_r  <= 36'(lim) * 36'(lim);
      st2_r   <= 34'(stick_radius) * 34'(stick_radius);
      rr2_r   <= 34'(launch_radius) * 34'(launch_radius);
    end
    if (cmd.wsq) begin
      sqx_r <= 40'(unsigned'(wxs));
      sqy_r <= 40'(unsigned'(wys));
    end
    if (cmd.rel) relaunch_r <= !active_r || (w2 > 41'(lim2_r));
    case (cmd.ui.uop)
      UOP_X:   x_r  <= xprod[36:7];
      UOP_X2:  x2_r <= 30'((60'(x_r) * 60'(x_r)) >> 30);
      UOP_QE: begin
        src_r  <= src;
        qest_r <= 31'((63'(src) * 63'(k_recip(cmd.ui.k))) >> 32);
      end
      UOP_QF:  t_r <= Q30_ONE - qfix;
      UOP_PM:  p_r <= 31'((61'(x2_r) * 61'(t_r)) >> 30);
      UOP_SIN: s_r <= 31'((61'(x_r) * 61'(t_r)) >> 30);
      default: ;
    endcase
    if (cmd.scale) begin
      stepx_r <= cn ? -COORD_W'(magx) : COORD_W'(magx);
      stepy_r <= sn ? -COORD_W'(magy) : COORD_W'(magy);
    end
    if (rd_go) begin
      rdx_r <= mem_x[rd_idx_r[AW-1:0]];
      rdy_r <= mem_y[rd_idx_r[AW-1:0]];
      z1_r  <= rd_idx_r == '0;
    end
    if (v1_r) begin
      dsx_r <= 42'(unsigned'(dxs));
      dsy_r <= 42'(unsigned'(dys));
    end
    if (cmd.decide && store) begin
      mem_x[count_r[AW-1:0]] <= wx_r[STORE_W-1:0];
      mem_y[count_r[AW-1:0]] <= wy_r[STORE_W-1:0];
    end
    if (cmd.tgt) event_r <= EV_TARGET;
    if (cmd.decide) event_r <= hit_r ? (store ? EV_STORED : EV_DROPPED) : EV_MOVING;
    if (cmd.publish) begin
      res_event <= event_r;
      res_x     <= wx_r;
      res_y     <= wy_r;
      res_count <= TARGET_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wx_r     <= '0;
      wy_r     <= '0;
      active_r <= 1'b0;
      count_r  <= CW'(1);
      rd_idx_r <= '0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      hit_r    <= 1'b0;
    end else begin
      if (cmd.move) begin
        wx_r     <= relaunch_r ? stepx_r : wx_r + stepx_r;
        wy_r     <= relaunch_r ? stepy_r : wy_r + stepy_r;
        active_r <= 1'b1;
      end
      if (cmd.scan_start) begin
        rd_idx_r <= '0;
        v1_r     <= 1'b0;
        v2_r     <= 1'b0;
        hit_r    <= 1'b0;
      end else begin
        v1_r <= rd_go;
        v2_r <= v1_r;
        if (rd_go) rd_idx_r <= rd_idx_r + CW'(1);
        if (v2_r && (d2 <= 43'(st2_r))) hit_r <= 1'b1;
      end
      if (cmd.decide) begin
        if (hit_r) active_r <= 1'b0;
        if (store) count_r <= count_r + CW'(1);
      end
    end
  end

endmodule

### sv/dpa_controller.sv
// Controller state machine: sequences one step and owns the handshakes.
// Depends on dpa_pkg; drives dpa_datapath through a command struct.
module dpa_controller (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  dpa_pkg::dp_status_t  status,
  output dpa_pkg::dp_cmd_t     cmd
);
  import dpa_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_PREP   = 8'b0000_0010,
    ST_DIR    = 8'b0000_0100,
    ST_SCALE  = 8'b0000_1000,
    ST_MOVE   = 8'b0001_0000,
    ST_SCST   = 8'b0010_0000,
    ST_SCAN   = 8'b0100_0000,
    ST_RESP   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.ui        = uprog(5'd31);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.full) begin
            cmd.tgt   = 1'b1;
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        cmd.wsq   = 1'b1;
        step_nxt  = '0;
        state_nxt = ST_DIR;
      end
      ST_DIR: begin
        cmd.ui   = uprog(step_r);
        cmd.rel  = step_r == '0;
        step_nxt = step_r + 5'd1;
        if (step_r == DIR_LAST) state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_MOVE;
      end
      ST_MOVE: begin
        cmd.move  = 1'b1;
        state_nxt = ST_SCST;
      end
      ST_SCST: begin
        cmd.scan_start = 1'b1;
        cmd.wsq        = 1'b1;
        state_nxt      = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.scan_done) begin
          cmd.decide = 1'b1;
          state_nxt  = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for dla_particle_aggregator_core: random angle words drive the
// walker, and a scoreboard predicts every result word from its own copy of the aggregate.
// Depends on dpa_pkg, dpa_in_if, dpa_out_if and the core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dpa_pkg::*;

  typedef struct {
    logic [EVENT_W-1:0]  ev;
    logic [COORD_W-1:0]  wx;
    logic [COORD_W-1:0]  wy;
    logic [TARGET_W-1:0] cnt;
  } step_word_t;

  class particle_scoreboard;
    longint px[1024];
    longint py[1024];
    longint cnt;
    longint wx, wy;
    bit     active;
    longint launch_r, stick_r, step_len, target;
    step_word_t pending_q[$];
    int     mismatches;

    function new();
      px[0] = 0;
      py[0] = 0;
      cnt = 1;
      wx = 0;
      wy = 0;
      active = 0;
      launch_r = 12800;
      stick_r = 256;
      step_len = 256;
      target = 1024;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, longint v);
      case (idx)
        REG_LAUNCH: launch_r = v & 'h1FFFF;
        REG_STICK:  stick_r = v & 'h1FFFF;
        REG_STEP:   step_len = v & 'h1FFFF;
        REG_TARGET: target = v & 'h7FF;
        default: ;
      endcase
    endfunction

    function longint qm(longint a, longint b);
      return (a * b) >>> 30;
    endfunction

    function longint sin_q30(longint x);
      longint x2, t;
      x2 = qm(x, x);
      t = (64'd1 << 30) - x2 / 72;
      t = (64'd1 << 30) - qm(x2, t) / 42;
      t = (64'd1 << 30) - qm(x2, t) / 20;
      t = (64'd1 << 30) - qm(x2, t) / 6;
      return qm(x, t);
    endfunction

    function longint cos_q30(longint x);
      longint x2, t;
      x2 = qm(x, x);
      t = (64'd1 << 30) - x2 / 90;
      t = (64'd1 << 30) - qm(x2, t) / 56;
      t = (64'd1 << 30) - qm(x2, t) / 30;
      t = (64'd1 << 30) - qm(x2, t) / 12;
      return (64'd1 << 30) - qm(x2, t) / 2;
    endfunction

    function longint scaled(longint len, longint mag, bit neg);
      longint p;
      p = (len * mag + (64'd1 << 29)) >>> 30;
      return neg ? -p : p;
    endfunction

    function longint wrap20(longint v);
      logic signed [19:0] w;
      w = v[19:0];
      return longint'(w);
    endfunction

    function void note_angle(logic [ANGLE_W-1:0] angle);
      longint phase, r, x, sa, ca, cm, sm, lim, st2, w2, dx, dy;
      bit cn, sn, hit;
      step_word_t e;
      longint eff;
      eff = target > 1024 ? 1024 : target;
      e.ev = EV_MOVING;
      if (cnt >= eff) begin
        e.ev = EV_TARGET;
      end else begin
        phase = longint'(angle) << 22;
        r = phase & ((64'd1 << 30) - 1);
        if (r <= (64'd1 << 29)) begin
          x = (r * longint'(PI4_Q30)) >>> 29;
          sa = sin_q30(x);
          ca = cos_q30(x);
        end else begin
          x = (((64'd1 << 30) - r) * longint'(PI4_Q30)) >>> 29;
          sa = cos_q30(x);
          ca = sin_q30(x);
        end
        case ((phase >> 30) & 3)
          0: begin cm = ca; cn = 0; sm = sa; sn = 0; end
          1: begin cm = sa; cn = 1; sm = ca; sn = 0; end
          2: begin cm = ca; cn = 1; sm = sa; sn = 1; end
          default: begin cm = sa; cn = 0; sm = ca; sn = 1; end
        endcase
        lim = launch_r + 128;
        if (!active || wx * wx + wy * wy > lim * lim) begin
          wx = scaled(launch_r, cm, cn);
          wy = scaled(launch_r, sm, sn);
          active = 1;
        end else begin
          wx = wrap20(wx + scaled(step_len, cm, cn));
          wy = wrap20(wy + scaled(step_len, sm, sn));
        end
        st2 = stick_r * stick_r;
        hit = 0;
        for (int i = 0; i < cnt && !hit; i++) begin
          dx = wx - px[i];
          dy = wy - py[i];
          if (dx * dx + dy * dy <= st2) hit = 1;
        end
        if (hit) begin
          w2 = wx * wx + wy * wy;
          active = 0;
          if (w2 < launch_r * launch_r && cnt < 1024) begin
            px[cnt] = wx;
            py[cnt] = wy;
            cnt++;
            e.ev = EV_STORED;
          end else begin
            e.ev = EV_DROPPED;
          end
        end
      end
      e.wx = wx[19:0];
      e.wy = wy[19:0];
      e.cnt = cnt[10:0];
      pending_q.push_back(e);
    endfunction

    function void check_word(step_word_t got);
      step_word_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word: ev=%0d", got.ev);
        return;
      end
      e = pending_q.pop_front();
      if (got.ev !== e.ev || got.wx !== e.wx || got.wy !== e.wy || got.cnt !== e.cnt) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected ev=%0d x=%h y=%h n=%0d, got ev=%0d x=%h y=%h n=%0d",
                   e.ev, e.wx, e.wy, e.cnt, got.ev, got.wx, got.wy, got.cnt);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_addr = REG_LAUNCH;
  logic [RADIUS_W-1:0] cfg_wdata = '0;
  int sent = 0;
  int received = 0;
  particle_scoreboard sb = new();

  dpa_in_if in_if();
  dpa_out_if out_if();

  dla_particle_aggregator_core dut (
    .clk(clk), .rst_n(rst_n), .in_word(in_if), .out_word(out_if),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    step_word_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.ev = out_if.event_res;
      got.wx = out_if.walker_x_out;
      got.wy = out_if.walker_y_out;
      got.cnt = out_if.stored_count;
      sb.check_word(got);
      received++;
    end
  end

  // Receiver: random stalls by phase, plus one long hold-off so the input backs up.
  initial begin
    int hold;
    bit held;
    out_if.ready = 0;
    held = 0;
    forever begin
      @(negedge clk);
      if (!held && received >= 120) begin
        held = 1;
        hold = 0;
        out_if.ready = 0;
        while (hold < 3000) begin
          @(negedge clk);
          hold++;
        end
      end
      if (sent < 200) out_if.ready = ($urandom_range(99) >= 59);
      else if (sent < 400) out_if.ready = ($urandom_range(99) >= 25);
      else out_if.ready = 1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [RADIUS_W-1:0] v);
    cfg_we = 1;
    cfg_addr = idx;
    cfg_wdata = v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic send_angle(logic [ANGLE_W-1:0] a);
    int gap_pct;
    gap_pct = sent < 200 ? 25 : (sent < 400 ? 59 : 0);
    while ($urandom_range(99) < gap_pct) begin
      in_if.valid = 0;
      @(negedge clk);
    end
    in_if.valid = 1;
    in_if.angle = a;
    do @(posedge clk); while (!in_if.ready);
    sb.note_angle(a);
    sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_if.valid = 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (1200) @(negedge clk);
  endtask

  task automatic run_phase(int lr, int sr, int sl, int tg, int n);
    settle();
    write_reg(REG_LAUNCH, RADIUS_W'(lr));
    write_reg(REG_STICK, RADIUS_W'(sr));
    write_reg(REG_STEP, RADIUS_W'(sl));
    write_reg(REG_TARGET, RADIUS_W'(tg));
    for (int i = 0; i < n; i++) send_angle(ANGLE_W'($urandom_range(1023)));
  endtask

  initial begin
    logic [ANGLE_W-1:0] corner[12];
    corner = '{0, 1, 127, 128, 255, 256, 384, 511, 512, 768, 896, 1023};
    in_if.valid = 0;
    in_if.angle = '0;
    repeat (6) @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    foreach (corner[i]) send_angle(corner[i]);
    run_phase(0, 0, 0, 1024, 4);
    run_phase(131071, 131071, 131071, 2047, 6);
    run_phase(2048, 512, 256, 60, 200);
    run_phase(1024, 300, 700, 40, 150);
    run_phase(3000, 768, 384, 0, 4);
    run_phase(3000, 768, 384, 1, 3);
    run_phase(2048, 512, 256, 1024, 200);
    settle();
    if (sb.pending_q.size() != 0) sb.mismatches++;
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
